@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the list RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define OLID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define OLID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/olid_pkg.sv @@
// Shared types and constants of the ordered list block.
// No dependencies; used by olid_cell, the top level, the checker and the testbench.
package olid_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 6;
  localparam int unsigned ValW     = 32;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    ActInsert = 3'd0,
    ActDelete = 3'd1,
    ActGet    = 3'd2,
    ActLocate = 3'd3,
    ActClear  = 3'd4
  } act_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic            ins;
    logic            del;
    logic [IdxW-1:0] slot;
    logic [ValW-1:0] val;
  } cell_cmd_t;

endpackage

@@ hw/rtl/olid_cell.sv @@
// One storage cell of the list row: holds one entry and shifts with neighbors.
// Depends on olid_pkg.
module olid_cell (
  input  logic                                clk_i,
  input  logic [olid_pkg::IdxW-1:0]           idx_i,
  input  olid_pkg::cell_cmd_t                 cmd_i,
  input  logic [olid_pkg::ValW-1:0]           left_i,
  input  logic [olid_pkg::ValW-1:0]           right_i,
  output logic [olid_pkg::ValW-1:0]           data_o,
  output logic                                hit_o,
  output logic                                match_o
);

  logic [olid_pkg::ValW-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (idx_i == cmd_i.slot) begin
        data_d = cmd_i.val;
      end else if (idx_i > cmd_i.slot) begin
        data_d = left_i;  // move up by one
      end
    end else if (cmd_i.del) begin
      if (idx_i >= cmd_i.slot) begin
        data_d = right_i; // close the gap
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign hit_o   = (idx_i == cmd_i.slot);
  assign match_o = (data_q == cmd_i.val);

endmodule

@@ hw/rtl/ordered_list_insert_delete_core.sv @@
// Top level of the ordered list block: command decode, row of cells, result register.
// Depends on olid_pkg, olid_cell and assert_macros.svh.
//
// Usage:
//   Drive action_i, position_i and element_value_i and raise start. A request is
//   taken at a rising edge with start high and busy low. busy stays low: the row
//   of cells shifts or compares every entry in parallel, so a request can be
//   issued on every clock (one transaction per cycle).
//   The result appears in the cycle after the request, on the result ports, with
//   done_o high for exactly that cycle. Throughput is one request per cycle, set
//   by the parallel update of the cell row.
//   Insert/delete move all later entries in the same edge; get and locate read
//   the row through an OR reduction and a first-match priority select.
//   The receiver cannot stall; each result is valid for its strobe cycle only.
//   Reset clears the length to zero and drops any pending strobe; the entries
//   themselves are not cleared and are read only below the current length.
`include "assert_macros.svh"

module ordered_list_insert_delete_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        action_i,
  input  logic [olid_pkg::PosW-1:0]         position_i,
  input  logic signed [olid_pkg::ValW-1:0]  element_value_i,
  output logic                              done_o,
  output logic                              failed_o,
  output logic signed [olid_pkg::ValW-1:0]  read_value_o,
  output logic [olid_pkg::PosW-1:0]         found_position_o,
  output logic [olid_pkg::PosW-1:0]         current_length_o,
  output logic                              is_empty_o
);

  localparam int unsigned Cap = olid_pkg::Capacity;

  logic                          accept;
  logic [olid_pkg::CntW-1:0]     cnt_d, cnt_q;
  logic [olid_pkg::CmpW:0]       pos_x, cnt_x;
  logic                          pos_nz, ins_ok, rd_ok;
  logic                          fail_d, done_q, failed_q;
  logic [olid_pkg::ValW-1:0]     rd_d, rd_q, sel_val;
  logic [olid_pkg::PosW-1:0]     found_d, found_q, first_hit;
  olid_pkg::cell_cmd_t           cmd;
  logic [olid_pkg::ValW-1:0]     cell_data [Cap];
  logic [Cap-1:0]                cell_hit, cell_match;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_x  = (olid_pkg::CmpW + 1)'(position_i);
  assign cnt_x  = (olid_pkg::CmpW + 1)'(cnt_q);
  assign pos_nz = (position_i != '0);
  assign ins_ok = pos_nz && (cnt_q != olid_pkg::CntW'(Cap)) && (pos_x <= cnt_x + 1'b1);
  assign rd_ok  = pos_nz && (pos_x <= cnt_x);

  // Broadcast command: shift the row only for an accepted request that succeeds.
  always_comb begin
    cmd.ins  = accept && (action_i == olid_pkg::ActInsert) && ins_ok;
    cmd.del  = accept && (action_i == olid_pkg::ActDelete) && rd_ok;
    cmd.slot = olid_pkg::IdxW'(position_i - 1'b1);
    cmd.val  = element_value_i;
  end

  // Decode the request into the result and the next length.
  always_comb begin
    cnt_d    = cnt_q;
    fail_d   = 1'b0;
    rd_d     = '0;
    found_d  = '0;
    unique case (action_i)
      olid_pkg::ActInsert: begin
        fail_d = !ins_ok;
        if (cmd.ins) cnt_d = cnt_q + 1'b1;
      end
      olid_pkg::ActDelete: begin
        fail_d = !rd_ok;
        if (rd_ok) rd_d = sel_val;
        if (cmd.del) cnt_d = cnt_q - 1'b1;
      end
      olid_pkg::ActGet: begin
        fail_d = !rd_ok;
        if (rd_ok) rd_d = sel_val;
      end
      olid_pkg::ActLocate: begin
        found_d = first_hit;
      end
      olid_pkg::ActClear: begin
        if (accept) cnt_d = '0;
      end
      default: begin
        fail_d = 1'b1;
      end
    endcase
  end

  // Row of cells; the end cells see themselves as their missing neighbor.
  for (genvar k = 0; k < Cap; k++) begin : g_cell
    olid_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (olid_pkg::IdxW'(k)),
      .cmd_i   (cmd),
      .left_i  (cell_data[(k > 0) ? k - 1 : k]),
      .right_i (cell_data[(k < Cap - 1) ? k + 1 : k]),
      .data_o  (cell_data[k]),
      .hit_o   (cell_hit[k]),
      .match_o (cell_match[k])
    );
  end

  // OR together the addressed entry.
  always_comb begin
    sel_val = '0;
    for (int k = 0; k < Cap; k++) begin
      sel_val = sel_val | (cell_data[k] & {olid_pkg::ValW{cell_hit[k]}});
    end
  end

  // First live match wins: scan from the top so the lowest index is kept.
  always_comb begin
    first_hit = '0;
    for (int k = Cap - 1; k >= 0; k--) begin
      if (cell_match[k] && (olid_pkg::CntW'(k) < cnt_q)) begin
        first_hit = olid_pkg::PosW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      failed_q <= fail_d;
      rd_q     <= rd_d;
      found_q  <= found_d;
    end
  end

  assign done_o           = done_q;
  assign failed_o         = failed_q;
  assign read_value_o     = rd_q;
  assign found_position_o = found_q;
  assign current_length_o = olid_pkg::PosW'(cnt_q);
  assign is_empty_o       = (cnt_q == '0);

  `OLID_ASSERT(a_done_follows_start, clk_i, rst_ni, accept |=> done_o,
               "missing result strobe")
  `OLID_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= olid_pkg::CntW'(Cap),
               "length above capacity")
  `OLID_ASSERT(a_fail_holds_len, clk_i, rst_ni,
               accept && fail_d |=> cnt_q == $past(cnt_q),
               "failed request changed length")
  `OLID_ASSERT(a_ins_grows, clk_i, rst_ni,
               cmd.ins |=> cnt_q == $past(cnt_q) + 1'b1,
               "insert did not grow list")

endmodule

@@ test/ordered_list_insert_delete_core_chk.sv @@
`timescale 1ns / 100ps
// Checker for the ordered list core: keeps its own copy of the list and
// predicts each result, then compares the strobed results in order.
// Depends on olid_pkg.
module ordered_list_insert_delete_core_chk (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [2:0]                       action_i,
  input  logic [olid_pkg::PosW-1:0]        position_i,
  input  logic signed [olid_pkg::ValW-1:0] element_value_i,
  input  logic                             done_i,
  input  logic                             failed_i,
  input  logic signed [olid_pkg::ValW-1:0] read_value_i,
  input  logic [olid_pkg::PosW-1:0]        found_position_i,
  input  logic [olid_pkg::PosW-1:0]        current_length_i,
  input  logic                             is_empty_i,
  output int                               pending_o,
  output int                               mismatches_o,
  output int                               length_o
);
  import olid_pkg::*;

  typedef struct packed {
    logic                   failed;
    logic signed [ValW-1:0] read_value;
    logic [PosW-1:0]        found_position;
    logic [PosW-1:0]        current_length;
    logic                   is_empty;
  } list_result_t;

  logic signed [ValW-1:0] entries [Capacity];
  int                     entry_cnt;
  list_result_t           pending_results [$];
  int                     mismatch_count;

  // Apply one request to the shadow list and return the result it causes.
  function automatic list_result_t apply_request(input logic [2:0] act,
                                                 input logic [PosW-1:0] pos,
                                                 input logic signed [ValW-1:0] val);
    list_result_t res;
    int           p;
    res = '0;
    p   = int'(pos);
    case (act)
      ActInsert: begin
        if (entry_cnt >= Capacity || p < 1 || p > entry_cnt + 1) begin
          res.failed = 1'b1;
        end else begin
          for (int k = entry_cnt; k >= p; k--) entries[k] = entries[k-1];
          entries[p-1] = val;
          entry_cnt++;
        end
      end
      ActDelete: begin
        if (p < 1 || p > entry_cnt) begin
          res.failed = 1'b1;
        end else begin
          res.read_value = entries[p-1];
          for (int k = p - 1; k + 1 < entry_cnt; k++) entries[k] = entries[k+1];
          entry_cnt--;
        end
      end
      ActGet: begin
        if (p < 1 || p > entry_cnt) res.failed = 1'b1;
        else res.read_value = entries[p-1];
      end
      ActLocate: begin
        // first match wins
        for (int k = entry_cnt - 1; k >= 0; k--) begin
          if (entries[k] == val) res.found_position = PosW'(k + 1);
        end
      end
      ActClear: begin
        entry_cnt = 0;
      end
      default: begin
        res.failed = 1'b1;
      end
    endcase
    res.current_length = PosW'(entry_cnt);
    res.is_empty       = (entry_cnt == 0);
    return res;
  endfunction

  function automatic int field_differs(input string name, input logic [ValW-1:0] want,
                                       input logic [ValW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      entry_cnt      = 0;
      mismatch_count = 0;
      pending_results.delete();
      pending_o    <= 0;
      mismatches_o <= 0;
      length_o     <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          mismatch_count += field_differs("failed", ValW'(want.failed), ValW'(failed_i));
          mismatch_count += field_differs("read_value", want.read_value, read_value_i);
          mismatch_count += field_differs("found_position", ValW'(want.found_position),
                                          ValW'(found_position_i));
          mismatch_count += field_differs("current_length", ValW'(want.current_length),
                                          ValW'(current_length_i));
          mismatch_count += field_differs("is_empty", ValW'(want.is_empty),
                                          ValW'(is_empty_i));
        end
      end
      if (start_i && !busy_i) begin
        pending_results.push_back(apply_request(action_i, position_i, element_value_i));
      end
      pending_o    <= pending_results.size();
      mismatches_o <= mismatch_count;
      length_o     <= entry_cnt;
    end
  end

endmodule

@@ test/ordered_list_insert_delete_core_tb.sv @@
`timescale 1ns / 100ps
// Top of the ordered list core testbench: clock, reset, request stimulus
// and verdict. Depends on olid_pkg, the core and ordered_list_insert_delete_core_chk.
module ordered_list_insert_delete_core_tb;
  import olid_pkg::*;

  localparam int NumActCodes    = 8;
  localparam int RequestsPerRun = 640;
  localparam int DrainCycles    = 8;
  localparam int CycleLimit     = 200000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [2:0]             action;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] element_value;
  logic                   done;
  logic                   failed;
  logic signed [ValW-1:0] read_value;
  logic [PosW-1:0]        found_position;
  logic [PosW-1:0]        current_length;
  logic                   is_empty;

  int pending;
  int mismatches;
  int list_len;
  int idle_pct;
  int cycle_count = 0;
  bit filling = 1'b1;

  ordered_list_insert_delete_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action),
    .position_i       (position),
    .element_value_i  (element_value),
    .done_o           (done),
    .failed_o         (failed),
    .read_value_o     (read_value),
    .found_position_o (found_position),
    .current_length_o (current_length),
    .is_empty_o       (is_empty)
  );

  ordered_list_insert_delete_core_chk u_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .action_i         (action),
    .position_i       (position),
    .element_value_i  (element_value),
    .done_i           (done),
    .failed_i         (failed),
    .read_value_i     (read_value),
    .found_position_i (found_position),
    .current_length_i (current_length),
    .is_empty_i       (is_empty),
    .pending_o        (pending),
    .mismatches_o     (mismatches),
    .length_o         (list_len)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request and hold it until the core takes it.
  // Each cycle idles with a chance of idle_pct in a hundred.
  task automatic issue(input logic [2:0] act, input logic [PosW-1:0] pos,
                       input logic signed [ValW-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    action        <= act;
    position      <= pos;
    element_value <= val;
    do @(posedge clk_i); while (busy);
  endtask

  // Mostly valid positions, with bursts that fill the list to capacity and
  // bursts that drain it; a small share of noise positions and codes.
  task automatic random_request();
    logic [2:0]             act;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] val;
    int                     len;
    int                     roll;
    len = list_len;
    if (len == 0) filling = 1'b1;
    else if (len >= Capacity && $urandom_range(3) == 0) filling = 1'b0;
    else if ($urandom_range(59) == 0) filling = ~filling;

    roll = $urandom_range(99);
    if (roll < 4)       act = 3'($urandom());
    else if (roll < 6)  act = ActClear;
    else if (roll < 60) act = filling ? ActInsert : ActDelete;
    else if (roll < 70) act = filling ? ActDelete : ActInsert;
    else if (roll < 85) act = ActGet;
    else                act = ActLocate;

    if ($urandom_range(99) < 85) begin
      if (act == ActInsert) pos = PosW'($urandom_range(1, len + 1));
      else if (len == 0)    pos = PosW'(1);
      else                  pos = PosW'($urandom_range(1, len));
    end else begin
      pos = PosW'($urandom());
    end

    // small values repeat often so locate hits and finds duplicates
    case ($urandom_range(9))
      0:             val = {1'b0, {(ValW-1){1'b1}}};
      1:             val = {1'b1, {(ValW-1){1'b0}}};
      2, 3, 4, 5, 6: val = $signed(ValW'($urandom_range(7))) - 4;
      default:       val = $urandom();
    endcase
    issue(act, pos, val);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    action        = ActInsert;
    position      = '0;
    element_value = '0;
    idle_pct      = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: reads and deletes refused, locate misses
    issue(ActGet, 1, 0);
    issue(ActDelete, 1, 0);
    issue(ActLocate, 1, 0);
    issue(ActInsert, 0, 5);
    issue(ActInsert, 2, 5);
    // build [min, 0, max, -1] through front, middle and tail inserts
    issue(ActInsert, 1, 32'sh7FFF_FFFF);
    issue(ActInsert, 1, 32'sh8000_0000);
    issue(ActInsert, 3, -1);
    issue(ActInsert, 2, 0);
    issue(ActInsert, 6'h3F, 7);
    issue(ActGet, 1, 0);
    issue(ActGet, 4, 0);
    issue(ActGet, 5, 0);
    issue(ActGet, 0, 0);
    issue(ActLocate, 0, -1);
    issue(ActLocate, 0, 12345);
    issue(ActDelete, 2, 0);
    issue(ActDelete, 4, 0);
    issue(ActDelete, 3, 0);
    for (int c = int'(ActClear) + 1; c < NumActCodes; c++) issue(3'(c), 1, 0);
    issue(ActClear, 6'h3F, 32'shFFFF_FFFF);
    issue(ActGet, 1, 0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 8 : (phase == 1) ? 79 : 0;
      repeat (RequestsPerRun) random_request();
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
